FILE: design/kwm_pkg.sv
// Shared constants and types for the k-way sorted record merge core.
// Used by kwm_rec_mem and kway_sorted_record_merge_core; depends on nothing.
package kwm_pkg;

  // List geometry
  localparam int unsigned LIST_COUNT  = 4;
  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned LIST_W      = $clog2(LIST_COUNT);
  localparam int unsigned POS_W       = $clog2(LIST_DEPTH);
  localparam int unsigned FILL_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADDR_W      = LIST_W + POS_W;
  localparam int unsigned STORE_DEPTH = LIST_COUNT * LIST_DEPTH;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned BARCODE_W = 64;
  localparam int unsigned TOTAL_W   = 38;
  localparam int unsigned ROUNDS_W  = 7;

  // Stream widths
  localparam int unsigned S_TDATA_W = 176;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 224;
  localparam int unsigned M_TUSER_W = 3;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MERGE = 1'b1;

  // One stored record
  typedef struct packed {
    logic [BARCODE_W-1:0] barcode;
    logic [SAMPLE_W-1:0]  sample;
    logic [COUNT_W-1:0]   count;
    logic [KEY_W-1:0]     key;
  } rec_t;

  // Write port of the record store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rec_t              data;
  } wr_t;

endpackage

FILE: design/kwm_rec_mem.sv
// Record store of the merge core: one write port, one registered read port.
// Depends on kwm_pkg for geometry and the record type.
module kwm_rec_mem (
  input  logic                       clk_i,
  input  kwm_pkg::wr_t               wr_i,
  input  logic                       rd_en_i,
  input  logic [kwm_pkg::ADDR_W-1:0] rd_addr_i,
  output kwm_pkg::rec_t              rd_data_o
);

  kwm_pkg::rec_t mem [kwm_pkg::STORE_DEPTH];
  kwm_pkg::rec_t rd_data_q;

  // Write one record
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read one record, hold the data while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/kway_sorted_record_merge_core.sv
// Top level of the k-way sorted record merge core.
// Depends on kwm_pkg and instantiates kwm_rec_mem.
//
// Load beats (tuser command 0) append a record to one of LIST_COUNT lists of
// LIST_DEPTH entries; a load into a full list is dropped and raises the
// overflow flag of the next merge. A merge beat (command 1) makes the block
// busy until the final result has been loaded into the output register. Each
// merge round first scans the list heads for the least key, then scans them
// again and emits every head equal to it in list order. Both scans go through
// the single read port of the record store and the 64-bit key comparators: an
// active list head is read and then compared, an exhausted list is skipped,
// and the final round stops at its last record. A stall of the output on the
// master side holds the merge.
// A merge with no stored records gives one result with the empty flag set.
// The store needs no clearing pass: fill levels alone decide what is read.
module kway_sorted_record_merge_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // target_key[63:0], record_count[95:64], sample_tag[111:96],
  // barcode_tag[175:112]
  input  logic [kwm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // command[0], list_index[2:1]
  input  logic [kwm_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_target[63:0], out_count[95:64], out_sample[111:96],
  // out_barcode[175:112], source_list[177:176], unique_targets[184:178],
  // total_count[222:185], zero[223]
  output logic [kwm_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // round_first[0], empty_merge[1], overflow[2]
  output logic [kwm_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FIND_RD  = 5'b00010,
    ST_FIND_CMP = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_CHK = 5'b10000
  } state_e;

  typedef logic [kwm_pkg::FILL_W-1:0] fill_t;

  state_e                        state_q, state_d;
  logic [kwm_pkg::LIST_W-1:0]    idx_q, idx_d;
  logic [kwm_pkg::KEY_W-1:0]     least_q, least_d;
  fill_t                         fill_q [kwm_pkg::LIST_COUNT];
  fill_t                         fill_d [kwm_pkg::LIST_COUNT];
  fill_t                         pos_q  [kwm_pkg::LIST_COUNT];
  fill_t                         pos_d  [kwm_pkg::LIST_COUNT];
  logic                          drop_q, drop_d;
  logic                          ovf_q, ovf_d;
  logic [kwm_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [kwm_pkg::ROUNDS_W-1:0]  rounds_q, rounds_d;
  logic [kwm_pkg::TOTAL_W-1:0]   total_q, total_d;
  logic                          first_q, first_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  kwm_pkg::rec_t                 out_rec_q, out_rec_d;
  logic [kwm_pkg::LIST_W-1:0]    out_src_q, out_src_d;
  logic                          out_new_q, out_new_d;
  logic                          out_empty_q, out_empty_d;
  logic                          out_last_q, out_last_d;
  logic [kwm_pkg::ROUNDS_W-1:0]  out_rounds_q, out_rounds_d;
  logic [kwm_pkg::TOTAL_W-1:0]   out_total_q, out_total_d;
  logic                          out_ovf_q, out_ovf_d;

  // Store access
  kwm_pkg::wr_t                  wr;
  logic                          rd_en;
  logic [kwm_pkg::ADDR_W-1:0]    rd_addr;
  kwm_pkg::rec_t                 rd_data;

  // Input beat fields
  logic                          s_fire;
  logic                          in_cmd;
  logic [kwm_pkg::LIST_W-1:0]    in_list;
  kwm_pkg::rec_t                 in_rec;

  logic                          out_free;
  logic                          head_active;
  logic                          idx_last;
  logic                          key_lt;
  logic                          key_eq;
  logic [kwm_pkg::CNT_W-1:0]     fill_sum;
  logic                          pos_ok;

  kwm_rec_mem u_rec_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Unpack the input beat
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd          = s_axis_tuser_i[0];
  assign in_list         = s_axis_tuser_i[2:1];
  assign in_rec.key      = s_axis_tdata_i[63:0];
  assign in_rec.count    = s_axis_tdata_i[95:64];
  assign in_rec.sample   = s_axis_tdata_i[111:96];
  assign in_rec.barcode  = s_axis_tdata_i[175:112];

  // Head of the list under scan and the key comparators
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign head_active = pos_q[idx_q] < fill_q[idx_q];
  assign idx_last    = idx_q == kwm_pkg::LIST_W'(kwm_pkg::LIST_COUNT - 1);
  assign rd_addr     = {idx_q, pos_q[idx_q][kwm_pkg::POS_W-1:0]};
  assign key_lt      = rd_data.key < least_q;
  assign key_eq      = rd_data.key == least_q;

  // Sum fill levels and check read positions
  always_comb begin
    fill_sum = '0;
    pos_ok   = 1'b1;
    for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
      fill_sum = fill_sum + kwm_pkg::CNT_W'(fill_q[i]);
      if (pos_q[i] > fill_q[i]) begin
        pos_ok = 1'b0;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    least_d      = least_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    drop_d       = drop_q;
    ovf_d        = ovf_q;
    rem_d        = rem_q;
    rounds_d     = rounds_q;
    total_d      = total_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_load     = 1'b0;
    out_rec_d    = rd_data;
    out_src_d    = idx_q;
    out_new_d    = first_q;
    out_empty_d  = 1'b0;
    out_last_d   = 1'b0;
    out_rounds_d = '0;
    out_total_d  = '0;
    out_ovf_d    = ovf_q;
    wr           = '0;
    rd_en        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (in_cmd == kwm_pkg::CMD_LOAD) begin
            // Append the record or drop it when the list is full
            if (fill_q[in_list] < fill_t'(kwm_pkg::LIST_DEPTH)) begin
              wr.en           = 1'b1;
              wr.addr         = {in_list, fill_q[in_list][kwm_pkg::POS_W-1:0]};
              wr.data         = in_rec;
              fill_d[in_list] = fill_q[in_list] + fill_t'(1);
            end else begin
              drop_d = 1'b1;
            end
          end else begin
            // Start a merge run
            for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
              pos_d[i] = '0;
            end
            ovf_d    = drop_q;
            rem_d    = fill_sum;
            rounds_d = '0;
            total_d  = '0;
            idx_d    = '0;
            least_d  = '1;
            state_d  = ST_FIND_RD;
          end
        end
      end

      ST_FIND_RD: begin
        if (rem_q == '0) begin
          // Nothing stored: an empty merge
          if (out_free) begin
            out_load    = 1'b1;
            out_rec_d   = '0;
            out_src_d   = '0;
            out_new_d   = 1'b0;
            out_empty_d = 1'b1;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
            drop_d      = 1'b0;
            for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
              fill_d[i] = '0;
              pos_d[i]  = '0;
            end
          end
        end else if (head_active) begin
          rd_en   = 1'b1;
          state_d = ST_FIND_CMP;
        end else if (idx_last) begin
          idx_d    = '0;
          rounds_d = rounds_q + kwm_pkg::ROUNDS_W'(1);
          first_d  = 1'b1;
          state_d  = ST_EMIT_RD;
        end else begin
          idx_d = idx_q + kwm_pkg::LIST_W'(1);
        end
      end

      ST_FIND_CMP: begin
        // Track the least head key
        if (key_lt) begin
          least_d = rd_data.key;
        end
        if (idx_last) begin
          idx_d    = '0;
          rounds_d = rounds_q + kwm_pkg::ROUNDS_W'(1);
          first_d  = 1'b1;
          state_d  = ST_EMIT_RD;
        end else begin
          idx_d   = idx_q + kwm_pkg::LIST_W'(1);
          state_d = ST_FIND_RD;
        end
      end

      ST_EMIT_RD: begin
        if (head_active) begin
          rd_en   = 1'b1;
          state_d = ST_EMIT_CHK;
        end else if (idx_last) begin
          idx_d   = '0;
          least_d = '1;
          state_d = ST_FIND_RD;
        end else begin
          idx_d = idx_q + kwm_pkg::LIST_W'(1);
        end
      end

      ST_EMIT_CHK: begin
        if (key_eq && !out_free) begin
          // Hold until the output register frees up
          state_d = ST_EMIT_CHK;
        end else begin
          if (key_eq) begin
            out_load      = 1'b1;
            pos_d[idx_q]  = pos_q[idx_q] + fill_t'(1);
            rem_d         = rem_q - kwm_pkg::CNT_W'(1);
            total_d       = total_q + kwm_pkg::TOTAL_W'(rd_data.count);
            first_d       = 1'b0;
          end
          if (key_eq && rem_q == kwm_pkg::CNT_W'(1)) begin
            // Final record: attach the run summary and clear the lists
            out_last_d   = 1'b1;
            out_rounds_d = rounds_q;
            out_total_d  = total_q + kwm_pkg::TOTAL_W'(rd_data.count);
            state_d      = ST_IDLE;
            drop_d       = 1'b0;
            for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
              fill_d[i] = '0;
              pos_d[i]  = '0;
            end
          end else if (idx_last) begin
            idx_d   = '0;
            least_d = '1;
            state_d = ST_FIND_RD;
          end else begin
            idx_d   = idx_q + kwm_pkg::LIST_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      drop_q      <= 1'b0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      rounds_q    <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < kwm_pkg::LIST_COUNT; i++) begin
        fill_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      drop_q      <= drop_d;
      ovf_q       <= ovf_d;
      rem_q       <= rem_d;
      rounds_q    <= rounds_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    least_q <= least_d;
    total_q <= total_d;
    if (out_load) begin
      out_rec_q    <= out_rec_d;
      out_src_q    <= out_src_d;
      out_new_q    <= out_new_d;
      out_empty_q  <= out_empty_d;
      out_last_q   <= out_last_d;
      out_rounds_q <= out_rounds_d;
      out_total_q  <= out_total_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  // Pack the output beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_empty_q, out_new_q};
  assign m_axis_tdata_o  = {1'b0, out_total_q, out_rounds_q, out_src_q,
                            out_rec_q.barcode, out_rec_q.sample,
                            out_rec_q.count, out_rec_q.key};

  // Records remain while a merge is in its compare or emit states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD || state_q == ST_EMIT_CHK || state_q == ST_FIND_CMP)
      |-> (rem_q != '0))
    else $error("merge running with no records left");

  // Read positions never pass fill levels
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_ok)
    else $error("read position beyond fill level");

  // Loading the final beat clears every list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (fill_sum == '0 && !drop_q && state_q == ST_IDLE))
    else $error("lists not cleared after merge");

  // A new beat is never loaded over one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !out_load)
    else $error("output beat overwritten");

endmodule

FILE: tb/sv/kway_sorted_record_merge_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for kway_sorted_record_merge_core: directed table, then
// random load/merge runs. Depends on kwm_pkg and the core; a behavioral merge
// predictor, or a typed row's known result, checks every output beat.
module kway_sorted_record_merge_core_tb;

  localparam int unsigned LIST_COUNT  = kwm_pkg::LIST_COUNT;
  localparam int unsigned LIST_DEPTH  = kwm_pkg::LIST_DEPTH;
  localparam int unsigned STORE_DEPTH = kwm_pkg::STORE_DEPTH;
  localparam int unsigned LIST_W      = kwm_pkg::LIST_W;
  localparam int unsigned KEY_W       = kwm_pkg::KEY_W;
  localparam int unsigned COUNT_W     = kwm_pkg::COUNT_W;
  localparam int unsigned SAMPLE_W    = kwm_pkg::SAMPLE_W;
  localparam int unsigned BARCODE_W   = kwm_pkg::BARCODE_W;
  localparam int unsigned TOTAL_W     = kwm_pkg::TOTAL_W;
  localparam int unsigned ROUNDS_W    = kwm_pkg::ROUNDS_W;
  localparam int unsigned S_TDATA_W   = kwm_pkg::S_TDATA_W;
  localparam int unsigned S_TUSER_W   = kwm_pkg::S_TUSER_W;
  localparam int unsigned M_TDATA_W   = kwm_pkg::M_TDATA_W;
  localparam int unsigned M_TUSER_W   = kwm_pkg::M_TUSER_W;

  localparam int RAND_BEATS  = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;

  // One output beat with its flags, laid out as {tdata, tlast, tuser}
  typedef struct packed {
    logic                 pad;
    logic [TOTAL_W-1:0]   total;
    logic [ROUNDS_W-1:0]  rounds;
    logic [LIST_W-1:0]    source;
    logic [BARCODE_W-1:0] barcode;
    logic [SAMPLE_W-1:0]  sample;
    logic [COUNT_W-1:0]   count;
    logic [KEY_W-1:0]     target;
    logic                 is_last;
    logic                 overflow;
    logic                 is_empty;
    logic                 round_first;
  } merge_out_t;

  // One row of the directed table; typed rows carry their known result
  typedef struct packed {
    logic              cmd;
    logic [LIST_W-1:0] lst;
    kwm_pkg::rec_t     r;
    logic [5:0]        reps;
    logic              typed;
    merge_out_t        golden;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic m_tlast;

  // Predictor state
  kwm_pkg::rec_t list_store [LIST_COUNT][LIST_DEPTH];
  int   fill_lvl [LIST_COUNT];
  logic lost_load = 1'b0;

  merge_out_t expected_results [$];
  stim_row_t  dir_rows [$];

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  kway_sorted_record_merge_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic merge_out_t mk_out(input logic [KEY_W-1:0] tgt,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [SAMPLE_W-1:0] smp,
                                        input logic [BARCODE_W-1:0] bc,
                                        input logic [LIST_W-1:0] src, input logic nt,
                                        input logic em, input logic lst_flag,
                                        input logic [ROUNDS_W-1:0] rnd,
                                        input logic [TOTAL_W-1:0] tot, input logic ovf);
    merge_out_t o;
    o.pad         = 1'b0;
    o.total       = tot;
    o.rounds      = rnd;
    o.source      = src;
    o.barcode     = bc;
    o.sample      = smp;
    o.count       = cnt;
    o.target      = tgt;
    o.is_last     = lst_flag;
    o.overflow    = ovf;
    o.is_empty    = em;
    o.round_first = nt;
    return o;
  endfunction

  function automatic string fmt_out(input merge_out_t o);
    return $sformatf({"tgt=%h cnt=%h smp=%h bc=%h src=%0d nt=%b em=%b last=%b",
                      " rnd=%0d tot=%h ovf=%b pad=%b"},
                     o.target, o.count, o.sample, o.barcode, o.source, o.round_first,
                     o.is_empty, o.is_last, o.rounds, o.total, o.overflow, o.pad);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Queue one expected output beat
  task automatic expect_beat(input merge_out_t o);
    expected_results = {expected_results, o};
  endtask

  // Update the list model with one beat; on a merge, queue the merged stream
  task automatic apply_beat(input logic cmd, input logic [LIST_W-1:0] lst,
                            input kwm_pkg::rec_t r, input bit keep);
    int pos [LIST_COUNT];
    int left;
    logic [ROUNDS_W-1:0] n_rounds;
    logic [TOTAL_W-1:0] run_total;
    logic [KEY_W-1:0] least;
    logic ovf;
    bit first;
    bit held;
    merge_out_t prev;
    if (cmd == kwm_pkg::CMD_LOAD) begin
      // Append, or drop and remember when the list is full
      if (fill_lvl[lst] < LIST_DEPTH) begin
        list_store[lst][fill_lvl[lst]] = r;
        fill_lvl[lst]++;
      end else begin
        lost_load = 1'b1;
      end
    end else begin
      ovf = lost_load;
      left = 0;
      n_rounds = '0;
      run_total = '0;
      held = 1'b0;
      prev = '0;
      for (int l = 0; l < LIST_COUNT; l++) begin
        pos[l] = 0;
        left += fill_lvl[l];
      end
      if (left == 0 && keep)
        expect_beat(mk_out('0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1, '0, '0, ovf));
      // Each round: find the least head, then emit every matching head in list order
      while (left > 0) begin
        least = '1;
        for (int l = 0; l < LIST_COUNT; l++) begin
          if (pos[l] < fill_lvl[l] && list_store[l][pos[l]].key < least)
            least = list_store[l][pos[l]].key;
        end
        n_rounds++;
        first = 1'b1;
        for (int l = 0; l < LIST_COUNT; l++) begin
          if (pos[l] < fill_lvl[l] && list_store[l][pos[l]].key == least) begin
            if (held && keep) expect_beat(prev);
            prev = mk_out(list_store[l][pos[l]].key, list_store[l][pos[l]].count,
                          list_store[l][pos[l]].sample, list_store[l][pos[l]].barcode,
                          LIST_W'(l), first, 1'b0, 1'b0, '0, '0, ovf);
            held = 1'b1;
            run_total = run_total + {{(TOTAL_W-COUNT_W){1'b0}}, list_store[l][pos[l]].count};
            first = 1'b0;
            pos[l]++;
            left--;
          end
        end
      end
      // Close the run with round count and total on the final beat
      if (held && keep) begin
        prev.is_last = 1'b1;
        prev.rounds  = n_rounds;
        prev.total   = run_total;
        expect_beat(prev);
      end
      for (int l = 0; l < LIST_COUNT; l++) fill_lvl[l] = 0;
      lost_load = 1'b0;
    end
  endtask

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [LIST_W-1:0] lst,
                           input kwm_pkg::rec_t r, input bit typed,
                           input merge_out_t golden);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    s_tuser  <= {lst, cmd};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_beat(cmd, lst, r, !typed);
    if (typed) expect_beat(golden);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic cmd, input logic [LIST_W-1:0] lst,
                         input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] cnt,
                         input logic [SAMPLE_W-1:0] smp, input logic [BARCODE_W-1:0] bc,
                         input int reps, input bit typed, input merge_out_t golden);
    stim_row_t row;
    row.cmd       = cmd;
    row.lst       = lst;
    row.r.key     = key;
    row.r.count   = cnt;
    row.r.sample  = smp;
    row.r.barcode = bc;
    row.reps      = 6'(reps);
    row.typed     = typed;
    row.golden    = golden;
    dir_rows = {dir_rows, row};
  endtask

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random ready gaps, one long hold-off, compare each beat
  initial begin : rx_side
    int wait_cyc;
    merge_out_t act;
    merge_out_t exp_out;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_cyc = (results_seen == HOLD_AT) ? HOLD_CYCLES :
                 rx_burst ? 0 : $urandom_range(0, 5);
      if (wait_cyc > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cyc) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      act = {m_tdata, m_tlast, m_tuser};
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected beat: %s", fmt_out(act)));
      end else begin
        exp_out = expected_results.pop_front();
        if (act !== exp_out)
          flag_error($sformatf("beat %0d mismatch\n  exp %s\n  act %s", results_seen,
                               fmt_out(exp_out), fmt_out(act)));
      end
      results_seen++;
      if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : main_seq
    kwm_pkg::rec_t r;
    int mode;
    int nloads;
    int imax;
    bit spread;
    logic [LIST_W-1:0] lst;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] next_key [LIST_COUNT];
    merge_out_t none;

    none = '0;
    for (int l = 0; l < LIST_COUNT; l++) fill_lvl[l] = 0;

    // Directed table: empty merge after reset, extreme single records, a full list
    // with a dropped load, an unsorted list and equal keys across lists
    add_row(kwm_pkg::CMD_MERGE, 2'd2, 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA, 16'h1234,
            64'hFEDC_BA98_7654_3210, 1, 1'b1,
            mk_out('0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1, '0, '0, 1'b0));
    add_row(kwm_pkg::CMD_LOAD, 2'd3, '1, '1, '1, '1, 1, 1'b0, none);
    add_row(kwm_pkg::CMD_MERGE, 2'd0, '0, '0, '0, '0, 1, 1'b1,
            mk_out('1, '1, '1, '1, 2'd3, 1'b1, 1'b0, 1'b1, 7'd1, 38'hFFFF_FFFF, 1'b0));
    add_row(kwm_pkg::CMD_LOAD, 2'd0, '0, '0, '0, '0, 1, 1'b0, none);
    add_row(kwm_pkg::CMD_MERGE, 2'd1, '1, '1, '1, '1, 1, 1'b1,
            mk_out('0, '0, '0, '0, 2'd0, 1'b1, 1'b0, 1'b1, 7'd1, '0, 1'b0));
    add_row(kwm_pkg::CMD_LOAD, 2'd1, 64'h10, 32'h100, 16'h0001, 64'hA000_0000_0000_0000,
            LIST_DEPTH + 1, 1'b0, none);
    add_row(kwm_pkg::CMD_LOAD, 2'd0, 64'h18, 32'h7, 16'h00F0, 64'h0B0B, 1, 1'b0, none);
    add_row(kwm_pkg::CMD_LOAD, 2'd0, 64'h11, 32'h9, 16'h0F00, 64'h0C0C, 1, 1'b0, none);
    add_row(kwm_pkg::CMD_LOAD, 2'd2, 64'h13, 32'hFFFF_FFFF, 16'hF000, 64'h0D0D, 1, 1'b0,
            none);
    add_row(kwm_pkg::CMD_MERGE, 2'd3, '0, '0, '0, '0, 1, 1'b0, none);
    add_row(kwm_pkg::CMD_MERGE, 2'd1, '0, '0, '0, '0, 1, 1'b1,
            mk_out('0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1, '0, '0, 1'b0));

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int i = 0; i < dir_rows.size(); i++) begin
      for (int rep = 0; rep < dir_rows[i].reps; rep++) begin
        r = dir_rows[i].r;
        r.key     = r.key + KEY_W'(rep);
        r.count   = r.count + COUNT_W'(rep);
        r.barcode = r.barcode + BARCODE_W'(rep);
        send_beat(dir_rows[i].cmd, dir_rows[i].lst, r, dir_rows[i].typed,
                  dir_rows[i].golden);
      end
    end

    // Random runs: mostly sorted lists ending in a merge, some full or overfilled,
    // some empty merges and some runs of unsorted noise
    while (beats_sent < RAND_BEATS) begin
      mode     = $urandom_range(0, 9);
      tx_burst = ($urandom_range(0, 3) == 0);
      spread   = $urandom_range(0, 1);
      imax     = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = {KEY_W{1'b1}} - 64'd300;
        default: base = {$urandom, $urandom};
      endcase
      for (int l = 0; l < LIST_COUNT; l++) next_key[l] = base + (spread ? KEY_W'(l) : '0);
      if (mode == 0) nloads = 0;
      else if (mode <= 2) nloads = $urandom_range(0, 1) ? STORE_DEPTH : $urandom_range(65, 72);
      else nloads = $urandom_range(1, 16);
      for (int k = 0; k < nloads; k++) begin
        lst = (mode <= 2 && k < STORE_DEPTH) ? LIST_W'(k) : LIST_W'($urandom_range(0, 3));
        r.key = (mode == 3) ? {$urandom, $urandom} : next_key[lst];
        next_key[lst] = next_key[lst] +
                        KEY_W'(spread ? 4 * $urandom_range(1, 3) : $urandom_range(0, imax));
        case ($urandom_range(0, 7))
          0:       r.count = '1;
          1:       r.count = '0;
          default: r.count = $urandom;
        endcase
        r.sample  = SAMPLE_W'($urandom);
        r.barcode = {$urandom, $urandom};
        send_beat(kwm_pkg::CMD_LOAD, lst, r, 1'b0, none);
      end
      r.key     = {$urandom, $urandom};
      r.count   = $urandom;
      r.sample  = SAMPLE_W'($urandom);
      r.barcode = {$urandom, $urandom};
      send_beat(kwm_pkg::CMD_MERGE, LIST_W'($urandom_range(0, 3)), r, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // Drain, then give stray beats a chance to show up
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
